// ===== src/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        OP_MAKE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_EQ   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZDEN  = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    // what the front end decides about an item
    typedef enum logic [1:0] {
        CL_REDUCE = 2'd0,
        CL_EQ     = 2'd1,
        CL_DIVZ   = 2'd2,
        CL_NONE   = 2'd3
    } t_class;

endpackage

// ===== src/rau_if.sv =====
// Valid/ready channel interface with payload.
`timescale 1ns / 1ps
interface rau_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit.
`timescale 1ns / 1ps
// Channel | Dir | Payload
// req     | in  | req_type, a_num, a_den, b_num, b_den
// rsp     | out | result_num, result_den, is_equal, status
//
// One item at a time in the back end: up to three WxW products (one a cycle),
// a binary gcd that shifts or subtracts once a cycle, then two restoring
// divisions. Equality, spare codes and divide-by-zero skip these steps and go
// from the queue straight to the result register. A two-beat queue lets the
// front accept while the back works. Reset is synchronous, active low; it
// clears the queue and the sequencer. The result register holds its beat
// until the sink takes it.
module rational_arithmetic_unit_core #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    rau_if.sink   req,
    rau_if.source rsp
);
    localparam int W = WORD_BITS;

    logic q_valid, q_ready;
    logic [(4*W+10)-1:0] q_item;
    logic [W-1:0] res_num;
    logic [W-2:0] res_den;
    logic res_eq;
    logic [1:0] res_st;

    // front end: decode and queue
    rau_front #(.W(W)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(req.valid), .o_ready(req.ready),
        .i_req_type(req.data.req_type),
        .i_a_num(req.data.a_num), .i_a_den(req.data.a_den),
        .i_b_num(req.data.b_num), .i_b_den(req.data.b_den),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    // back end: products, gcd, divisions
    rau_back #(.W(W)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(rsp.valid), .i_ready(rsp.ready),
        .o_num(res_num), .o_den(res_den), .o_eq(res_eq), .o_status(res_st)
    );

    assign rsp.data.result_num = res_num;
    assign rsp.data.result_den = res_den;
    assign rsp.data.is_equal   = res_eq;
    assign rsp.data.status     = res_st;
endmodule

// ===== src/rau_front.sv =====
// Front end: accept requests, decode, sign-split operands, queue work.
`timescale 1ns / 1ps
module rau_front #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [2:0]   i_req_type,
    input  logic [W-1:0] i_a_num,
    input  logic [W-1:0] i_a_den,
    input  logic [W-1:0] i_b_num,
    input  logic [W-1:0] i_b_den,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [(4*W+10)-1:0] o_item
);
    localparam int QD = rau_pkg::QUEUE_DEPTH;

    typedef struct packed {
        rau_pkg::t_class cls;
        logic [2:0]      op;
        logic            eq;
        logic            an_s;
        logic [W-1:0]    an_m;
        logic            ad_s;
        logic [W-1:0]    ad_m;
        logic            bn_s;
        logic [W-1:0]    bn_m;
        logic            bd_s;
        logic [W-1:0]    bd_m;
    } t_item;

    t_item r_q [QD];
    logic [$clog2(QD+1)-1:0] r_cnt;
    logic [$clog2(QD)-1:0]   r_wp, r_rp;
    t_item n_item;
    logic  push, pop;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    always_comb begin
        n_item      = '0;
        n_item.op   = i_req_type;
        n_item.an_s = i_a_num[W-1];
        n_item.an_m = mag(i_a_num);
        n_item.ad_s = i_a_den[W-1];
        n_item.ad_m = mag(i_a_den);
        n_item.bn_s = i_b_num[W-1];
        n_item.bn_m = mag(i_b_num);
        n_item.bd_s = i_b_den[W-1];
        n_item.bd_m = mag(i_b_den);
        n_item.eq   = (i_a_num == i_b_num) && (i_a_den == i_b_den);
        case (i_req_type)
            rau_pkg::OP_MAKE, rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL:
                n_item.cls = rau_pkg::CL_REDUCE;
            rau_pkg::OP_DIV:
                n_item.cls = (i_b_num == '0) ? rau_pkg::CL_DIVZ : rau_pkg::CL_REDUCE;
            rau_pkg::OP_EQ: n_item.cls = rau_pkg::CL_EQ;
            default:        n_item.cls = rau_pkg::CL_NONE;
        endcase
    end

    assign o_ready = (r_cnt != QD[$bits(r_cnt)-1:0]);
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= n_item;
                r_wp      <= r_wp + 1'b1;
            end
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{($bits(r_cnt)-1){1'b0}}, push} -
                     {{($bits(r_cnt)-1){1'b0}}, pop};
        end
    end
endmodule

// ===== src/rau_back.sv =====
// Back end: cross products, binary gcd, two restoring divisions, result register.
`timescale 1ns / 1ps
module rau_back #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [(4*W+10)-1:0] i_item,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_num,
    output logic [W-2:0] o_den,
    output logic         o_eq,
    output logic [1:0]   o_status
);
    localparam int PW = 2*W;          // product width
    localparam int NW = 2*W + 1;      // sum width
    localparam int KW = $clog2(NW + 1);
    localparam int CW = $clog2(NW + 1);

    typedef struct packed {
        rau_pkg::t_class cls;
        logic [2:0]      op;
        logic            eq;
        logic            an_s;
        logic [W-1:0]    an_m;
        logic            ad_s;
        logic [W-1:0]    ad_m;
        logic            bn_s;
        logic [W-1:0]    bn_m;
        logic            bd_s;
        logic [W-1:0]    bd_m;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GPRE, S_GODD,
        S_GLOOP, S_GSHL, S_DIV, S_FIN, S_OUT
    } t_state;

    t_item          it;
    t_state         r_state;
    rau_pkg::t_op   r_op;
    logic [W-1:0]   r_x, r_y;
    logic [PW-1:0]  r_p1, r_p2, r_p3;
    logic           r_s1, r_s2, r_s3;
    logic [NW-1:0]  r_nm, r_dm;
    logic           r_ns, r_ds;
    logic [NW-1:0]  r_ga, r_gb;
    logic [KW-1:0]  r_k;
    logic [NW-1:0]  r_q, r_r, r_dq, r_n2;
    logic [CW-1:0]  r_cnt;
    logic           r_second;
    logic [1:0]     r_st;
    logic           r_ovalid;
    logic [W-1:0]   r_onum;
    logic [W-2:0]   r_oden;
    logic           r_oeq;
    logic [1:0]     r_ost;
    t_item          r_it;

    logic [PW-1:0]  mul_out;
    logic [NW-1:0]  sum_mag;
    logic           sum_s;
    logic [NW:0]    rem_sh;
    logic [NW:0]    rem_sub;

    assign it       = t_item'(i_item);
    assign mul_out  = PW'(r_x) * PW'(r_y);
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_num    = r_onum;
    assign o_den    = r_oden;
    assign o_eq     = r_oeq;
    assign o_status = r_ost;

    // signed-magnitude add of the two numerator products
    always_comb begin
        if (r_s1 == r_s2) begin
            sum_mag = NW'(r_p1) + NW'(r_p2);
            sum_s   = r_s1;
        end else if (r_p1 >= r_p2) begin
            sum_mag = NW'(r_p1 - r_p2);
            sum_s   = r_s1;
        end else begin
            sum_mag = NW'(r_p2 - r_p1);
            sum_s   = r_s2;
        end
    end

    assign rem_sh  = {r_r, r_q[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_FIN) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_it <= it;
                        r_op <= rau_pkg::t_op'(it.op);
                        r_st <= rau_pkg::ST_OK;
                        case (it.cls)
                            rau_pkg::CL_REDUCE: begin
                                case (it.op)
                                    rau_pkg::OP_MAKE: begin
                                        r_nm <= NW'(it.an_m);
                                        r_ns <= it.an_s;
                                        r_dm <= NW'(it.ad_m);
                                        r_ds <= it.ad_s;
                                        r_state <= S_GPRE;
                                    end
                                    rau_pkg::OP_MUL: begin
                                        r_x <= it.an_m; r_y <= it.bn_m;
                                        r_state <= S_MUL1;
                                    end
                                    default: begin
                                        r_x <= it.an_m; r_y <= it.bd_m;
                                        r_state <= S_MUL1;
                                    end
                                endcase
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_MUL1: begin
                    // first product: an*bd (add/sub/div) or an*bn (mul)
                    r_p1 <= mul_out;
                    r_s1 <= (r_op == rau_pkg::OP_MUL) ? (r_it.an_s ^ r_it.bn_s)
                                                      : (r_it.an_s ^ r_it.bd_s);
                    if (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) begin
                        r_x <= r_it.ad_m;
                        r_y <= (r_op == rau_pkg::OP_DIV) ? r_it.bn_m : r_it.bd_m;
                    end else begin
                        r_x <= r_it.bn_m; r_y <= r_it.ad_m;
                    end
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2 <= mul_out;
                    if (r_op == rau_pkg::OP_DIV)
                        r_s2 <= r_it.ad_s ^ r_it.bn_s;
                    else if (r_op == rau_pkg::OP_MUL)
                        r_s2 <= r_it.ad_s ^ r_it.bd_s;
                    else
                        r_s2 <= (r_it.bn_s ^ (r_op == rau_pkg::OP_SUB)) ^ r_it.ad_s;
                    r_x <= r_it.ad_m; r_y <= r_it.bd_m;
                    r_state <= (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB)
                               ? S_MUL3 : S_COMB;
                end
                S_MUL3: begin
                    r_p3 <= mul_out;
                    r_s3 <= r_it.ad_s ^ r_it.bd_s;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) begin
                        r_nm <= sum_mag; r_ns <= sum_s;
                        r_dm <= NW'(r_p3); r_ds <= r_s3;
                    end else begin
                        r_nm <= NW'(r_p1); r_ns <= r_s1;
                        r_dm <= NW'(r_p2); r_ds <= r_s2;
                    end
                    r_state <= S_GPRE;
                end
                S_GPRE: begin
                    // replace a zero denominator, seed the gcd
                    r_k <= '0;
                    if (r_dm == '0) begin
                        r_dm <= NW'(1); r_ds <= 1'b0; r_st <= rau_pkg::ST_ZDEN;
                        r_gb <= NW'(1);
                    end else begin
                        r_gb <= r_dm;
                    end
                    if (r_nm == '0) begin
                        r_ga    <= (r_dm == '0) ? NW'(1) : r_dm;
                        r_state <= S_GSHL;
                    end else begin
                        r_ga    <= r_nm;
                        r_state <= S_GODD;
                    end
                end
                S_GODD: begin
                    // strip common factors of two, then make a odd
                    if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1; r_gb <= r_gb >> 1; r_k <= r_k + 1'b1;
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else begin
                        r_state <= S_GLOOP;
                    end
                end
                S_GLOOP: begin
                    if (r_gb == '0) begin
                        r_state <= S_GSHL;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga > r_gb) begin
                        r_ga <= r_gb; r_gb <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                S_GSHL: begin
                    if (r_k != '0) begin
                        r_ga <= r_ga << 1; r_k <= r_k - 1'b1;
                    end else begin
                        r_dq <= r_ga; r_q <= r_nm; r_r <= '0;
                        r_cnt <= CW'(NW); r_second <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one restoring step per cycle
                    if (r_cnt != '0) begin
                        if (!rem_sub[NW]) begin
                            r_r <= rem_sub[NW-1:0];
                            r_q <= {r_q[NW-2:0], 1'b1};
                        end else begin
                            r_r <= rem_sh[NW-1:0];
                            r_q <= {r_q[NW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else if (!r_second) begin
                        r_n2 <= r_q; r_q <= r_dm; r_r <= '0;
                        r_cnt <= CW'(NW); r_second <= 1'b1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_onum <= '0; r_oden <= '0; r_oeq <= 1'b0;
                        r_ost <= rau_pkg::ST_OK;
                        case (r_it.cls)
                            rau_pkg::CL_EQ:   r_oeq <= r_it.eq;
                            rau_pkg::CL_DIVZ: begin
                                r_oden <= (W-1)'(1); r_ost <= rau_pkg::ST_DIVZ;
                            end
                            rau_pkg::CL_REDUCE: begin
                                // r_n2 numerator, r_q denominator
                                r_onum <= ((r_n2 != '0) && (r_ns != r_ds))
                                          ? (~r_n2[W-1:0] + W'(1)) : r_n2[W-1:0];
                                r_oden <= r_q[W-2:0];
                                if ((r_n2[NW-1:W-1] != '0 &&
                                     !((r_n2 != '0) && (r_ns != r_ds) &&
                                       r_n2 == (NW'(1) << (W-1)))) ||
                                    r_q[NW-1:W-1] != '0)
                                    r_ost <= rau_pkg::ST_OVF;
                                else
                                    r_ost <= r_st;
                            end
                            default: ;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
